[hdl/psc_pkg.sv]
// psc_pkg: widths, constants and shared types of the pressure sensor compensation pipeline
package psc_pkg;

    // field widths at the ports
    localparam int RAW_W     = 24;
    localparam int CAL_W     = 16;
    localparam int PM_W      = 15;
    localparam int TC_W      = 8;
    localparam int TDATA_IN_W  = 2 * RAW_W;
    localparam int TDATA_OUT_W = 24;
    localparam int CFG_IDX_W = 3;

    // internal widths, sized to the value ranges
    localparam int DT_W      = RAW_W + 1;
    localparam int PROD_W    = DT_W + CAL_W + 1;
    localparam int DTSQ_W    = 2 * RAW_W;
    localparam int TEMP_W    = 19;
    localparam int OFF_W     = 36;
    localparam int SENS_W    = 35;
    localparam int TI_LO_W   = 17;
    localparam int TI_HI_W   = 12;
    localparam int SQ_W      = 34;
    localparam int TT_W      = 20;
    localparam int OFFI_W    = 38;
    localparam int SENSI_W   = 37;
    localparam int TMAG_W    = 14;
    localparam int TQ_W      = TC_W - 1;
    localparam int ACC_W     = 40;
    localparam int HALF_W    = ACC_W / 2;
    localparam int PP_W      = RAW_W + HALF_W;
    localparam int X_W       = 64;
    localparam int Y_W       = 43;
    localparam int Z_W       = 44;
    localparam int Q_W       = 31;
    localparam int QV_W      = 19;

    // pipeline depth in register stages ahead of the output buffer
    localparam int PIPE_STAGES = 12;

    // scaling shifts of the compensation formulas
    localparam int C5_SHIFT    = 8;
    localparam int TEMP_SHIFT  = 23;
    localparam int C2_SHIFT    = 16;
    localparam int OFF_SHIFT   = 7;
    localparam int C1_SHIFT    = 15;
    localparam int SENS_SHIFT  = 8;
    localparam int TI_LO_SHIFT = 33;
    localparam int TI_HI_SHIFT = 36;
    localparam int P_SHIFT     = 21;
    localparam int Q_SHIFT     = 13;

    // temperature breakpoints in 0.01 C
    localparam int TEMP_REF  = 2000;
    localparam int VLOW_OFS  = 1500;

    // reciprocal multipliers for divide by 100 and by 10
    localparam int RECIP100       = 10486;
    localparam int RECIP100_SHIFT = 20;
    localparam int TPROD_W        = RECIP100_SHIFT + TQ_W;
    localparam int RECIP10        = 419431;
    localparam int RECIP10_SHIFT  = 22;

    // output limits and the raw thresholds that map to them
    localparam int P_MAX = 30000;
    localparam int T_MIN = -40;
    localparam int T_MAX = 125;
    localparam int TT_LO = -4099;
    localparam int TT_HI = 12599;
    localparam int Q_LO  = -9;
    localparam int Q_HI  = 300009;

    // calibration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C1 = 3'd0,
        CFG_C2 = 3'd1,
        CFG_C3 = 3'd2,
        CFG_C4 = 3'd3,
        CFG_C5 = 3'd4,
        CFG_C6 = 3'd5
    } t_cfg_idx;

    // calibration words
    typedef struct packed {
        logic [CAL_W-1:0] c1;
        logic [CAL_W-1:0] c2;
        logic [CAL_W-1:0] c3;
        logic [CAL_W-1:0] c4;
        logic [CAL_W-1:0] c5;
        logic [CAL_W-1:0] c6;
    } t_cal;

    // hand-off from the compensation front end to the pressure back end
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [ACC_W-1:0]  off2;
        logic signed [ACC_W-1:0]  sens2;
        logic [TPROD_W-1:0]       tprod;
        logic                     tneg;
        logic                     tlo;
        logic                     thi;
    } t_front;

    // one result beat
    typedef struct packed {
        logic                    clipped;
        logic signed [TC_W-1:0]  temperature_c;
        logic [PM_W-1:0]         pressure_mbar;
    } t_result;

endpackage

[hdl/psc_pipe_ctrl.sv]
// psc_pipe_ctrl: valid bits that travel with the data through the pipeline stages
module psc_pipe_ctrl import psc_pkg::*; #(
    parameter int STAGES = PIPE_STAGES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_adv,
    output logic o_in_ready,
    output logic o_last_valid
);

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] n_valid;

    // shift the valid bits along with the stage registers
    always_comb begin
        n_valid = {r_valid[STAGES-2:0], i_in_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready   = i_adv;
    assign o_last_valid = r_valid[STAGES-1];

endmodule

[hdl/psc_front.sv]
// psc_front: first-order terms and second-order corrections, stages 0 to 5
module psc_front import psc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  t_cal             i_cal,
    input  logic [RAW_W-1:0] i_raw_pressure,
    input  logic [RAW_W-1:0] i_raw_temperature,
    output t_front           o_front
);

    // stage 0
    logic signed [DT_W-1:0]   r0_dt;
    logic [RAW_W-1:0]         r0_d1;
    // stage 1
    logic signed [PROD_W-1:0] r1_pt;
    logic signed [PROD_W-1:0] r1_po;
    logic signed [PROD_W-1:0] r1_ps;
    logic [DTSQ_W-1:0]        r1_dtsq;
    logic [RAW_W-1:0]         r1_d1;
    // stage 2
    logic signed [TEMP_W-1:0] r2_temp;
    logic signed [OFF_W-1:0]  r2_off;
    logic signed [SENS_W-1:0] r2_sens;
    logic [TI_LO_W-1:0]       r2_ti_lo;
    logic [TI_HI_W-1:0]       r2_ti_hi;
    logic [RAW_W-1:0]         r2_d1;
    // stage 3
    logic [SQ_W-1:0]          r3_sq;
    logic [SQ_W-1:0]          r3_esq;
    logic                     r3_low;
    logic                     r3_vlow;
    logic signed [TT_W-1:0]   r3_tt;
    logic signed [OFF_W-1:0]  r3_off;
    logic signed [SENS_W-1:0] r3_sens;
    logic [RAW_W-1:0]         r3_d1;
    // stage 4
    logic [OFFI_W-1:0]        r4_offi;
    logic [SENSI_W-1:0]       r4_sensi;
    logic                     r4_tlo;
    logic                     r4_thi;
    logic                     r4_tneg;
    logic [TMAG_W-1:0]        r4_tmag;
    logic signed [OFF_W-1:0]  r4_off;
    logic signed [SENS_W-1:0] r4_sens;
    logic [RAW_W-1:0]         r4_d1;
    // stage 5
    logic signed [ACC_W-1:0]  r5_off2;
    logic signed [ACC_W-1:0]  r5_sens2;
    logic [TPROD_W-1:0]       r5_tprod;
    logic                     r5_tneg;
    logic                     r5_tlo;
    logic                     r5_thi;
    logic [RAW_W-1:0]         r5_d1;

    logic signed [2*DT_W-1:0]   w_dtsq;
    logic signed [PROD_W-1:0]   w_pt_b;
    logic signed [PROD_W-1:0]   w_po_b;
    logic signed [PROD_W-1:0]   w_ps_b;
    logic signed [PROD_W-1:0]   w_pt_q;
    logic signed [PROD_W-1:0]   w_po_q;
    logic signed [PROD_W-1:0]   w_ps_q;
    logic [DTSQ_W+1:0]          w_dtsq3;
    logic signed [TEMP_W-1:0]   w_dev;
    logic signed [TEMP_W-1:0]   w_e;
    logic signed [2*TEMP_W-1:0] w_sq;
    logic signed [2*TEMP_W-1:0] w_esq;
    logic                       w_low;
    logic [TI_LO_W-1:0]         w_ti;
    logic [SQ_W+1:0]            w_sq3;
    logic [SQ_W+2:0]            w_sq5;
    logic [SQ_W+2:0]            w_esq7;
    logic [OFFI_W-1:0]          w_offi;
    logic [SENSI_W-1:0]         w_sensi;
    logic [TT_W-1:0]            w_tabs;
    logic [2*TMAG_W-1:0]        w_tprod;

    // dt squared for the low-temperature correction of TEMP
    assign w_dtsq = r0_dt * r0_dt;

    // truncating shifts: bias negative values before the arithmetic shift
    assign w_pt_b = r1_pt + $signed({{(PROD_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{r1_pt[PROD_W-1]}}});
    assign w_po_b = r1_po + $signed({{(PROD_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{r1_po[PROD_W-1]}}});
    assign w_ps_b = r1_ps + $signed({{(PROD_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{r1_ps[PROD_W-1]}}});
    assign w_pt_q = w_pt_b >>> TEMP_SHIFT;
    assign w_po_q = w_po_b >>> OFF_SHIFT;
    assign w_ps_q = w_ps_b >>> SENS_SHIFT;
    assign w_dtsq3 = {2'b00, r1_dtsq} + {1'b0, r1_dtsq, 1'b0};

    // deviation from 20 C and from -15 C, and the Ti pick
    assign w_dev = r2_temp - $signed(TEMP_W'(TEMP_REF));
    assign w_e   = r2_temp + $signed(TEMP_W'(VLOW_OFS));
    assign w_sq  = w_dev * w_dev;
    assign w_esq = w_e * w_e;
    assign w_low = r2_temp < $signed(TEMP_W'(TEMP_REF));
    assign w_ti  = w_low ? r2_ti_lo : TI_LO_W'(r2_ti_hi);

    // OFFi and SENSi by branch
    assign w_sq3  = {2'b00, r3_sq} + {1'b0, r3_sq, 1'b0};
    assign w_sq5  = {1'b0, r3_sq, 2'b00} + {3'b000, r3_sq};
    assign w_esq7 = {r3_esq, 3'b000} - {3'b000, r3_esq};

    always_comb begin
        if (r3_low) begin
            w_offi  = OFFI_W'(w_sq3[SQ_W+1:1])
                    + (r3_vlow ? OFFI_W'(w_esq7) : OFFI_W'(0));
            w_sensi = SENSI_W'(w_sq5[SQ_W+2:3])
                    + (r3_vlow ? SENSI_W'({r3_esq, 2'b00}) : SENSI_W'(0));
        end else begin
            w_offi  = OFFI_W'(r3_sq[SQ_W-1:4]);
            w_sensi = '0;
        end
    end

    // magnitude of the temperature word for the divide by 100
    assign w_tabs  = r3_tt[TT_W-1] ? TT_W'(-r3_tt) : TT_W'(r3_tt);
    assign w_tprod = r4_tmag * TMAG_W'(RECIP100);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 0: dT
            r0_dt    <= $signed({1'b0, i_raw_temperature})
                      - $signed({1'b0, i_cal.c5, {C5_SHIFT{1'b0}}});
            r0_d1    <= i_raw_pressure;
            // stage 1: coefficient products
            r1_pt    <= r0_dt * $signed({1'b0, i_cal.c6});
            r1_po    <= r0_dt * $signed({1'b0, i_cal.c4});
            r1_ps    <= r0_dt * $signed({1'b0, i_cal.c3});
            r1_dtsq  <= w_dtsq[DTSQ_W-1:0];
            r1_d1    <= r0_d1;
            // stage 2: TEMP, OFF, SENS and both Ti candidates
            r2_temp  <= w_pt_q[TEMP_W-1:0] + TEMP_W'(TEMP_REF);
            r2_off   <= $signed({{(OFF_W-CAL_W-C2_SHIFT){1'b0}}, i_cal.c2, {C2_SHIFT{1'b0}}})
                      + w_po_q[OFF_W-1:0];
            r2_sens  <= $signed({{(SENS_W-CAL_W-C1_SHIFT){1'b0}}, i_cal.c1, {C1_SHIFT{1'b0}}})
                      + w_ps_q[SENS_W-1:0];
            r2_ti_lo <= w_dtsq3[TI_LO_SHIFT +: TI_LO_W];
            r2_ti_hi <= r1_dtsq[TI_HI_SHIFT +: TI_HI_W];
            r2_d1    <= r1_d1;
            // stage 3: squares, branch flags, TEMP - Ti
            r3_sq    <= w_sq[SQ_W-1:0];
            r3_esq   <= w_esq[SQ_W-1:0];
            r3_low   <= w_low;
            r3_vlow  <= r2_temp < $signed(TEMP_W'(-VLOW_OFS));
            r3_tt    <= $signed({r2_temp[TEMP_W-1], r2_temp})
                      - $signed({{(TT_W-TI_LO_W){1'b0}}, w_ti});
            r3_off   <= r2_off;
            r3_sens  <= r2_sens;
            r3_d1    <= r2_d1;
            // stage 4: corrections and temperature range flags
            r4_offi  <= w_offi;
            r4_sensi <= w_sensi;
            r4_tlo   <= r3_tt < $signed(TT_W'(TT_LO));
            r4_thi   <= r3_tt > $signed(TT_W'(TT_HI));
            r4_tneg  <= r3_tt[TT_W-1];
            r4_tmag  <= w_tabs[TMAG_W-1:0];
            r4_off   <= r3_off;
            r4_sens  <= r3_sens;
            r4_d1    <= r3_d1;
            // stage 5: corrected OFF and SENS, scaled temperature
            r5_off2  <= $signed({{(ACC_W-OFF_W){r4_off[OFF_W-1]}}, r4_off})
                      - $signed({{(ACC_W-OFFI_W){1'b0}}, r4_offi});
            r5_sens2 <= $signed({{(ACC_W-SENS_W){r4_sens[SENS_W-1]}}, r4_sens})
                      - $signed({{(ACC_W-SENSI_W){1'b0}}, r4_sensi});
            r5_tprod <= w_tprod[TPROD_W-1:0];
            r5_tneg  <= r4_tneg;
            r5_tlo   <= r4_tlo;
            r5_thi   <= r4_thi;
            r5_d1    <= r4_d1;
        end
    end

    always_comb begin
        o_front.d1    = r5_d1;
        o_front.off2  = r5_off2;
        o_front.sens2 = r5_sens2;
        o_front.tprod = r5_tprod;
        o_front.tneg  = r5_tneg;
        o_front.tlo   = r5_tlo;
        o_front.thi   = r5_thi;
    end

endmodule

[hdl/psc_pressure.sv]
// psc_pressure: pressure product, scaling and saturation, stages 6 to 11
module psc_pressure import psc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_en,
    input  t_front  i_front,
    output t_result o_result
);

    // stage 6
    logic [PP_W-1:0]          r6_plo;
    logic signed [PP_W-1:0]   r6_phi;
    logic signed [ACC_W-1:0]  r6_off2;
    logic signed [TC_W-1:0]   r6_temp;
    logic                     r6_tclip;
    // stage 7
    logic signed [X_W-1:0]    r7_x;
    logic signed [ACC_W-1:0]  r7_off2;
    // stage 8
    logic signed [Y_W-1:0]    r8_y;
    logic signed [ACC_W-1:0]  r8_off2;
    // stage 9
    logic signed [Z_W-1:0]    r9_z;
    // stage 10
    logic signed [Q_W-1:0]    r10_q;
    // stage 11
    logic                     r11_qlo;
    logic                     r11_qneg;
    logic                     r11_qhi;
    logic [PM_W-1:0]          r11_p;
    // temperature result riding along, stages 7 to 11
    logic [TC_W:0]            r_tdly [7:11];

    logic [PP_W-1:0]          w_plo;
    logic signed [PP_W:0]     w_phi;
    logic [TQ_W-1:0]          w_tq;
    logic [TC_W-1:0]          w_tval;
    logic signed [X_W-1:0]    w_xb;
    logic signed [X_W-1:0]    w_y;
    logic signed [Z_W-1:0]    w_zb;
    logic signed [Z_W-1:0]    w_q;
    logic [2*QV_W-1:0]        w_pprod;

    // D1 times SENS in two partial products
    assign w_plo = i_front.d1 * i_front.sens2[HALF_W-1:0];
    assign w_phi = $signed({1'b0, i_front.d1}) * $signed(i_front.sens2[ACC_W-1:HALF_W]);

    // temperature divide by 100 finished, sign restored
    assign w_tq   = i_front.tprod[TPROD_W-1:RECIP100_SHIFT];
    assign w_tval = i_front.tneg ? (TC_W'(0) - {1'b0, w_tq}) : {1'b0, w_tq};

    // truncating shifts toward zero
    assign w_xb = r7_x + $signed({{(X_W-P_SHIFT){1'b0}}, {P_SHIFT{r7_x[X_W-1]}}});
    assign w_y  = w_xb >>> P_SHIFT;
    assign w_zb = r9_z + $signed({{(Z_W-Q_SHIFT){1'b0}}, {Q_SHIFT{r9_z[Z_W-1]}}});
    assign w_q  = w_zb >>> Q_SHIFT;

    // divide by 10 by reciprocal, exact over the unclipped range
    assign w_pprod = r10_q[QV_W-1:0] * QV_W'(RECIP10);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 6: partial products, final temperature
            r6_plo   <= w_plo;
            r6_phi   <= w_phi[PP_W-1:0];
            r6_off2  <= i_front.off2;
            r6_tclip <= i_front.tlo | i_front.thi;
            if (i_front.tlo) begin
                r6_temp <= TC_W'(T_MIN);
            end else if (i_front.thi) begin
                r6_temp <= TC_W'(T_MAX);
            end else begin
                r6_temp <= w_tval;
            end
            // stage 7: full product
            r7_x     <= $signed({r6_phi, {HALF_W{1'b0}}})
                      + $signed({{(X_W-PP_W){1'b0}}, r6_plo});
            r7_off2  <= r6_off2;
            // stage 8: product over 2^21
            r8_y     <= w_y[Y_W-1:0];
            r8_off2  <= r7_off2;
            // stage 9: minus OFF
            r9_z     <= $signed({{(Z_W-Y_W){r8_y[Y_W-1]}}, r8_y})
                      - $signed({{(Z_W-ACC_W){r8_off2[ACC_W-1]}}, r8_off2});
            // stage 10: over 2^13
            r10_q    <= w_q[Q_W-1:0];
            // stage 11: range flags and millibar value
            r11_qlo  <= r10_q < $signed(Q_W'(Q_LO));
            r11_qneg <= r10_q[Q_W-1];
            r11_qhi  <= r10_q > $signed(Q_W'(Q_HI));
            r11_p    <= w_pprod[RECIP10_SHIFT +: PM_W];
            // temperature delay line
            r_tdly[7] <= {r6_tclip, r6_temp};
            for (int k = 8; k <= 11; k++) begin
                r_tdly[k] <= r_tdly[k-1];
            end
        end
    end

    // saturation of the pressure result
    always_comb begin
        if (r11_qneg) begin
            o_result.pressure_mbar = '0;
        end else if (r11_qhi) begin
            o_result.pressure_mbar = PM_W'(P_MAX);
        end else begin
            o_result.pressure_mbar = r11_p;
        end
        o_result.temperature_c = r_tdly[11][TC_W-1:0];
        o_result.clipped       = r11_qlo | r11_qhi | r_tdly[11][TC_W];
    end

endmodule

[hdl/psc_out_skid.sv]
// psc_out_skid: two-entry output buffer between the pipeline and the result stream
module psc_out_skid import psc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_out_valid;
    logic    r_spare_valid;
    t_result r_out;
    t_result r_spare;
    logic    w_take;

    assign w_take = r_out_valid & i_ready;

    // output register refills from the spare entry first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_spare_valid <= 1'b0;
        end else if (w_take || !r_out_valid) begin
            if (r_spare_valid) begin
                r_out         <= r_spare;
                r_out_valid   <= 1'b1;
                r_spare_valid <= i_push;
                if (i_push) begin
                    r_spare <= i_data;
                end
            end else begin
                r_out_valid <= i_push;
                if (i_push) begin
                    r_out <= i_data;
                end
            end
        end else if (i_push) begin
            r_spare       <= i_data;
            r_spare_valid <= 1'b1;
        end
    end

    assign o_room  = ~r_spare_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // a beat is never pushed into a full buffer
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_spare_valid)
        else $error("result pushed into full output buffer");

    // the spare entry is only in use behind a waiting output beat
    a_spare_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare_valid |-> r_out_valid)
        else $error("spare entry held without output beat");
`endif

endmodule

[hdl/pressure_sensor_compensation.sv]
// pressure_sensor_compensation: top level, calibration registers, pipeline and output buffer
// An accepted beat runs through 12 register stages, then the output buffer, and waits
// there while the result side stalls. Throughput: one beat per cycle while the buffer has
// room; the stage depth is set by one multiplier or one wide add per stage, and a two-entry
// output buffer keeps input open while a result waits.
// Reset (i_rst_n low, synchronous): calibration words go to zero and all valid bits clear.
module pressure_sensor_compensation import psc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // calibration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CAL_W-1:0]       i_cfg_data,
    // raw conversion stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: raw_pressure [23:0], raw_temperature [47:24]
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,
    // result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: pressure_mbar [14:0], temperature_c [22:15], zero [23]
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,
    // tuser: clipped [0]
    output logic                   o_m_axis_tuser
);

    t_cal    r_cal;
    t_cal    n_cal;
    t_front  w_front;
    t_result w_result;
    t_result w_out;
    logic    w_adv;
    logic    w_last_valid;

    // calibration register writes, unknown indexes ignored
    always_comb begin
        n_cal = r_cal;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_C1:  n_cal.c1 = i_cfg_data;
                CFG_C2:  n_cal.c2 = i_cfg_data;
                CFG_C3:  n_cal.c3 = i_cfg_data;
                CFG_C4:  n_cal.c4 = i_cfg_data;
                CFG_C5:  n_cal.c5 = i_cfg_data;
                CFG_C6:  n_cal.c6 = i_cfg_data;
                default: n_cal = r_cal;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else begin
            r_cal <= n_cal;
        end
    end

    // valid tracking, stalls only when the output buffer is full
    psc_pipe_ctrl #(
        .STAGES (PIPE_STAGES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_adv        (w_adv),
        .o_in_ready   (o_s_axis_tready),
        .o_last_valid (w_last_valid)
    );

    // first-order terms and corrections
    psc_front u_front (
        .i_clk             (i_clk),
        .i_en              (w_adv),
        .i_cal             (r_cal),
        .i_raw_pressure    (i_s_axis_tdata[RAW_W-1:0]),
        .i_raw_temperature (i_s_axis_tdata[TDATA_IN_W-1:RAW_W]),
        .o_front           (w_front)
    );

    // pressure scaling and saturation
    psc_pressure u_pressure (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_front  (w_front),
        .o_result (w_result)
    );

    // output buffer
    psc_out_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_adv & w_last_valid),
        .i_data  (w_result),
        .o_room  (w_adv),
        .o_valid (o_m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {{(TDATA_OUT_W-PM_W-TC_W){1'b0}},
                             w_out.temperature_c, w_out.pressure_mbar};
    assign o_m_axis_tuser = w_out.clipped;

`ifndef SYNTHESIS
    // pressure never leaves its saturation range
    a_pressure_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[PM_W-1:0] <= PM_W'(P_MAX)))
        else $error("pressure result above full scale");

    // temperature never leaves its saturation range
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[PM_W +: TC_W]) >= $signed(TC_W'(T_MIN))) &&
            ($signed(o_m_axis_tdata[PM_W +: TC_W]) <= $signed(TC_W'(T_MAX))))
        else $error("temperature result outside saturation range");
`endif

endmodule
